@@ design/vsfp_pkg.sv @@
`default_nettype none

package vsfp_pkg;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MARKER = 3'd0,
        REG_END_MARKER   = 3'd1,
        REG_PULSE_MIN    = 3'd2,
        REG_PULSE_MAX    = 3'd3,
        REG_OXYGEN_MIN   = 3'd4,
        REG_OXYGEN_MAX   = 3'd5,
        REG_HEAT_MIN     = 3'd6,
        REG_HEAT_MAX     = 3'd7
    } reg_index_t;

    // Register reset values
    localparam logic [7:0] RST_START_MARKER = 8'd0;
    localparam logic [7:0] RST_END_MARKER   = 8'd0;
    localparam logic [7:0] RST_PULSE_MIN    = 8'd40;
    localparam logic [7:0] RST_PULSE_MAX    = 8'd90;
    localparam logic [7:0] RST_OXYGEN_MIN   = 8'd75;
    localparam logic [7:0] RST_OXYGEN_MAX   = 8'd100;
    localparam logic [7:0] RST_HEAT_MIN     = 8'd20;
    localparam logic [7:0] RST_HEAT_MAX     = 8'd40;

    // Frame layout: four 32-bit words, sent LSB first
    localparam int unsigned WORD_CNT = 4;
    localparam int unsigned BYTE_CNT_W = 4;
    localparam logic [1:0] WORD_ID     = 2'd0;
    localparam logic [1:0] WORD_HEAT   = 2'd1;
    localparam logic [1:0] WORD_PULSE  = 2'd2;
    localparam logic [1:0] WORD_OXYGEN = 2'd3;
    localparam logic [BYTE_CNT_W-1:0] LAST_BODY_BYTE = 4'd15;

    // Divide by 1000 through a reciprocal multiply. Only dividends below
    // 2^18 can give a quotient that fits a window (quotient <= 262), and
    // with a 28-bit shift the rounding error stays below one LSB there.
    localparam int unsigned SCALE_DIV   = 1000;
    localparam int unsigned DIVIDEND_W  = 18;
    localparam int unsigned RECIP_SHIFT = 28;
    localparam int unsigned RECIP_W     = 19;
    localparam int unsigned RECIP_MULT  =
        ((1 << RECIP_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
    localparam int unsigned PROD_W      = DIVIDEND_W + RECIP_W;
    localparam int unsigned QUOT_W      = 9;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_BODY,
        ST_FINGER,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic body_wr;
        logic finger_wr;
        logic close_fire;
    } frame_ctl_t;

endpackage

`default_nettype wire

@@ design/vital_signs_frame_parser_core.sv @@
`default_nettype none

// Vital-signs frame parser. Takes one received byte per item on the input
// channel and accepts an item every clock cycle. In the hunt state bytes are
// dropped until one equals start_marker; the next 16 bytes form four
// little-endian words (device id, temperature, heart rate, saturation), then
// one finger-status byte and one closing byte follow. A start marker inside a
// frame is plain data. The closing byte produces one result item, held in the
// output register from the next cycle on. frame_ok is set when the closing
// byte equals end_marker; only then are temperature and saturation divided by
// 1000. A zero finger byte zeroes heart rate and saturation, and each vital
// is zeroed unless its value, after any divide, lies in its inclusive window (an
// empty window always gives zero). The input stalls only while a result sits
// in the output register with the output stalled; otherwise the rate is one
// byte per cycle, set by the single output register. Configuration writes
// take effect at the next edge and belong in idle periods.
module vital_signs_frame_parser_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [31:0]                         device_id,
    output logic [7:0]                          temperature,
    output logic [7:0]                          pulse,
    output logic [7:0]                          oxygen,
    output logic [7:0]                          finger_present,
    output logic                                frame_ok,
    input  logic                                cfg_we,
    input  logic [vsfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vsfp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vsfp_pkg::*;

    // Window check, with optional divide by 1000 ahead of it
    function automatic logic [7:0] check_vital(
        input logic [31:0] v,
        input logic        scale,
        input logic [7:0]  lo,
        input logic [7:0]  hi
    );
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] val;
        logic              fits;
        prod = {{RECIP_W{1'b0}}, v[DIVIDEND_W-1:0]}
             * {{DIVIDEND_W{1'b0}}, RECIP_MULT[RECIP_W-1:0]};
        if (scale)
        begin
            fits = (v[31:DIVIDEND_W] == '0);
            val  = prod[RECIP_SHIFT +: QUOT_W];
        end
        else
        begin
            fits = (v[31:8] == '0);
            val  = {1'b0, v[7:0]};
        end
        if (fits && (val >= {1'b0, lo}) && (val <= {1'b0, hi}))
            return val[7:0];
        return 8'd0;
    endfunction

    // Configuration registers
    logic [7:0] start_marker_reg, end_marker_reg;
    logic [7:0] pulse_min_reg, pulse_max_reg;
    logic [7:0] oxygen_min_reg, oxygen_max_reg;
    logic [7:0] heat_min_reg, heat_max_reg;

    // Frame control
    state_t                 state_reg, state_next;
    logic [BYTE_CNT_W-1:0]  byte_cnt_reg, byte_cnt_next;
    frame_ctl_t             ctl;
    logic                   accept;

    // Frame payload (no reset needed)
    logic [31:0] word_reg [WORD_CNT];
    logic [7:0]  finger_reg;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] device_id_reg;
    logic [7:0]  temperature_reg, pulse_reg, oxygen_reg, finger_out_reg;
    logic        frame_ok_reg;
    logic        close_ok;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign close_ok = (rx_byte == end_marker_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= RST_START_MARKER;
            end_marker_reg   <= RST_END_MARKER;
            pulse_min_reg    <= RST_PULSE_MIN;
            pulse_max_reg    <= RST_PULSE_MAX;
            oxygen_min_reg   <= RST_OXYGEN_MIN;
            oxygen_max_reg   <= RST_OXYGEN_MAX;
            heat_min_reg     <= RST_HEAT_MIN;
            heat_max_reg     <= RST_HEAT_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_MARKER: start_marker_reg <= cfg_data;
                REG_END_MARKER:   end_marker_reg   <= cfg_data;
                REG_PULSE_MIN:    pulse_min_reg    <= cfg_data;
                REG_PULSE_MAX:    pulse_max_reg    <= cfg_data;
                REG_OXYGEN_MIN:   oxygen_min_reg   <= cfg_data;
                REG_OXYGEN_MAX:   oxygen_max_reg   <= cfg_data;
                REG_HEAT_MIN:     heat_min_reg     <= cfg_data;
                REG_HEAT_MAX:     heat_max_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT:
                if (accept && (rx_byte == start_marker_reg))
                    state_next = ST_BODY;
            ST_BODY:
                if (accept && (byte_cnt_reg == LAST_BODY_BYTE))
                    state_next = ST_FINGER;
            ST_FINGER:
                if (accept)
                    state_next = ST_CLOSE;
            ST_CLOSE:
                if (accept)
                    state_next = ST_HUNT;
            default:
                state_next = ST_HUNT;
        endcase
    end

    // State outputs
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ST_BODY:   ctl.body_wr    = accept;
            ST_FINGER: ctl.finger_wr  = accept;
            ST_CLOSE:  ctl.close_fire = accept;
            default:   ctl = '0;
        endcase
    end

    // Counter wraps 15 -> 0, so it is zero again when the body ends
    assign byte_cnt_next = ctl.body_wr ? byte_cnt_reg + 1'b1 : byte_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_HUNT;
            byte_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    // Byte lanes: every lane of every word is rewritten before the close
    always_ff @(posedge clk)
    begin
        if (ctl.body_wr)
            word_reg[byte_cnt_reg[3:2]][{byte_cnt_reg[1:0], 3'b000} +: 8] <= rx_byte;
        if (ctl.finger_wr)
            finger_reg <= rx_byte;
    end

    // Output register; close_fire implies the slot is free
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.close_fire)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.close_fire)
        begin
            device_id_reg   <= word_reg[WORD_ID];
            temperature_reg <= check_vital(word_reg[WORD_HEAT], close_ok,
                                           heat_min_reg, heat_max_reg);
            pulse_reg       <= (finger_reg == 8'd0) ? 8'd0 :
                               check_vital(word_reg[WORD_PULSE], 1'b0,
                                           pulse_min_reg, pulse_max_reg);
            oxygen_reg      <= (finger_reg == 8'd0) ? 8'd0 :
                               check_vital(word_reg[WORD_OXYGEN], close_ok,
                                           oxygen_min_reg, oxygen_max_reg);
            finger_out_reg  <= finger_reg;
            frame_ok_reg    <= close_ok;
        end
    end

    assign out_valid      = out_valid_reg;
    assign device_id      = device_id_reg;
    assign temperature    = temperature_reg;
    assign pulse          = pulse_reg;
    assign oxygen         = oxygen_reg;
    assign finger_present = finger_out_reg;
    assign frame_ok       = frame_ok_reg;

endmodule

`default_nettype wire

@@ design/vsfp_checker.sv @@
`default_nettype none

module vsfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] device_id,
    input logic [7:0]  temperature,
    input logic [7:0]  pulse,
    input logic [7:0]  oxygen,
    input logic [7:0]  finger_present,
    input logic        frame_ok
);

    // A held result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(device_id) && $stable(temperature)
            && $stable(pulse) && $stable(oxygen) && $stable(frame_ok))
        else $error("stalled result changed");

    // Input backpressure only comes from a blocked output register
    a_in_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    // No finger means no heart rate and no saturation
    a_no_finger: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (finger_present == 8'd0) |-> (pulse == 8'd0) && (oxygen == 8'd0))
        else $error("vitals reported without finger");

endmodule

bind vital_signs_frame_parser_core vsfp_checker u_vsfp_checker (.*);

`default_nettype wire
